// ===== rtl/spc_pkg.sv =====
// Shared types, register indexes and fixed field widths of the sphere-plane collision block.
`default_nettype none

package spc_pkg;

    // Fixed widths of the fields and registers.
    localparam int VAL_W     = 32;
    localparam int NRM_W     = 18;
    localparam int RAD_W     = 31;
    localparam int RST_W     = 17;
    localparam int RST_FRAC  = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_X     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Y     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_Z     = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RESTITUTION = 4'd7;

    localparam logic [RST_W-1:0] RESET_RESTITUTION = 17'd52429;

    typedef enum logic [1:0] {
        CS_NONE      = 2'd0,
        CS_COLLISION = 2'd1,
        CS_RESTING   = 2'd2
    } t_contact;

    typedef struct packed {
        logic signed [VAL_W-1:0] vel_x;
        logic signed [VAL_W-1:0] vel_y;
        logic signed [VAL_W-1:0] vel_z;
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        t_contact                contact_state;
        logic signed [VAL_W-1:0] new_vel_x;
        logic signed [VAL_W-1:0] new_vel_y;
        logic signed [VAL_W-1:0] new_vel_z;
        logic signed [VAL_W-1:0] normal_speed;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/sphere_plane_collision_response.sv =====
// Top level of the pipelined sphere-plane collision response block.
//
// The block takes one transaction per clock cycle: o_busy never rises, so a
// transaction is accepted at every edge where i_start is high. Each accepted
// transaction produces exactly one result, shown for one cycle with o_done
// high; the receiver cannot stall it. In order, the stages of the datapath
// pipeline are: products with the normal, the dot and distance sums, the
// normal-part products, rounding, the restitution products, the squares, the
// small test and bounce rounding, and the final classification with
// saturation into the output register. Configuration writes are accepted in
// every cycle and must be made while no transaction is in flight; they take
// effect for transactions accepted after the write.
`default_nettype none

module sphere_plane_collision_response
    import spc_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire t_in                  i_item,
    output logic                      o_done,
    output t_out                      o_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    // The normal register must also hold 1.0 at its reset value.
    localparam int NW   = (FRACTION_BITS + 2 > NRM_W) ? FRACTION_BITS + 2 : NRM_W;
    localparam int PDW  = VAL_W + NW;          // velocity times normal
    localparam int DW   = PDW + 3;             // dot sum with rounding headroom
    localparam int SW   = DW - FRACTION_BITS;  // normal speed
    localparam int DDW  = VAL_W + 1 + NW;      // offset times normal
    localparam int DSW  = DDW + 2;             // signed distance
    localparam int CMPW = (DSW > RAD_W + FRACTION_BITS) ? DSW : RAD_W + FRACTION_BITS;
    localparam int PRW  = SW + NW;             // speed times normal
    localparam int PW   = PRW + 1 - FRACTION_BITS; // normal part
    localparam int RPW  = PW + RST_W + 1;      // restitution times normal part
    localparam int BW   = RPW + 1 - RST_FRAC;  // rounded bounce term
    localparam int EW   = ((PW > VAL_W) ? PW : VAL_W) + 4;
    localparam int THR  = ((1 << FRACTION_BITS) + 5) / 10;
    localparam int THR_W = $clog2(THR);
    localparam int SQW  = 2 * THR_W + 2;
    localparam int LAT  = 7;

    localparam logic signed [DW-1:0]  RND_D = DW'(1) << (FRACTION_BITS - 1);
    localparam logic signed [PRW:0]   RND_P = (PRW + 1)'(1) << (FRACTION_BITS - 1);
    localparam logic signed [RPW:0]   RND_R = (RPW + 1)'(1) << (RST_FRAC - 1);
    localparam logic [SQW-1:0]        THR_SQ = SQW'(longint'(THR) * longint'(THR));

    function automatic logic [VAL_W-1:0] sat32(input logic signed [EW-1:0] x);
        logic [EW-VAL_W:0] hi;
        hi = x[EW-1:VAL_W-1];
        if (hi == '0 || hi == '1) begin
            return x[VAL_W-1:0];
        end else if (x[EW-1]) begin
            return {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_W-1){1'b1}}};
        end
    endfunction

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    logic signed [NW-1:0]    cfg_nrm [3];
    logic signed [VAL_W-1:0] cfg_pnt [3];
    logic [RAD_W-1:0]        cfg_radius;
    logic [RST_W-1:0]        cfg_rest;

    spc_cfg_regs #(
        .FRACTION_BITS (FRACTION_BITS),
        .NORMAL_W      (NW)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_nrm       (cfg_nrm),
        .o_pnt       (cfg_pnt),
        .o_radius    (cfg_radius),
        .o_rest      (cfg_rest)
    );

    // Nothing in the pipeline can hold an item back.
    assign o_busy = 1'b0;

    logic in_accept;
    assign in_accept = i_start && !o_busy;

    // Valid bits travel alongside the data, one per stage.
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], in_accept};
        end
    end

    logic signed [VAL_W-1:0] in_v [3];
    logic signed [VAL_W-1:0] in_c [3];

    assign in_v[0] = i_item.vel_x;
    assign in_v[1] = i_item.vel_y;
    assign in_v[2] = i_item.vel_z;
    assign in_c[0] = i_item.pos_x;
    assign in_c[1] = i_item.pos_y;
    assign in_c[2] = i_item.pos_z;

    // ---------------------------------------------------------------------
    // Stage 1: velocity and centre offset multiplied by the normal.
    // ---------------------------------------------------------------------
    logic signed [VAL_W-1:0] r_s1_v  [3];
    logic signed [PDW-1:0]   r_s1_dp [3];
    logic signed [DDW-1:0]   r_s1_dd [3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1_v[i]  <= in_v[i];
            r_s1_dp[i] <= PDW'(in_v[i]) * PDW'(cfg_nrm[i]);
            r_s1_dd[i] <= DDW'(DDW'(in_c[i]) - DDW'(cfg_pnt[i])) * DDW'(cfg_nrm[i]);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: dot product rounded to the normal speed, and the distance.
    // ---------------------------------------------------------------------
    logic signed [VAL_W-1:0] r_s2_v [3];
    logic signed [SW-1:0]    r_s2_s;
    logic signed [DSW-1:0]   r_s2_dist;
    logic signed [DW-1:0]    n_s2_dot;

    assign n_s2_dot = DW'(r_s1_dp[0]) + DW'(r_s1_dp[1]) + DW'(r_s1_dp[2]) + RND_D;

    always_ff @(posedge i_clk) begin
        r_s2_v    <= r_s1_v;
        r_s2_s    <= SW'(n_s2_dot >>> FRACTION_BITS);
        r_s2_dist <= DSW'(r_s1_dd[0]) + DSW'(r_s1_dd[1]) + DSW'(r_s1_dd[2]);
    end

    // ---------------------------------------------------------------------
    // Stage 3: normal-part products and the distance test against the radius.
    // ---------------------------------------------------------------------
    logic signed [VAL_W-1:0] r_s3_v    [3];
    logic signed [PRW-1:0]   r_s3_prod [3];
    logic signed [SW-1:0]    r_s3_s;
    logic                    r_s3_le;
    logic                    r_s3_eq;
    logic [DSW-1:0]          n_s3_ad;
    logic [CMPW-1:0]         n_s3_rs;

    assign n_s3_ad = r_s2_dist[DSW-1] ? DSW'(-r_s2_dist) : DSW'(r_s2_dist);
    assign n_s3_rs = CMPW'(cfg_radius) << FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s3_prod[i] <= PRW'(r_s2_s) * PRW'(cfg_nrm[i]);
        end
        r_s3_v  <= r_s2_v;
        r_s3_s  <= r_s2_s;
        r_s3_le <= CMPW'(n_s3_ad) <= n_s3_rs;
        r_s3_eq <= CMPW'(n_s3_ad) == n_s3_rs;
    end

    // ---------------------------------------------------------------------
    // Stage 4: normal part rounded half up.
    // ---------------------------------------------------------------------
    logic signed [VAL_W-1:0] r_s4_v [3];
    logic signed [PW-1:0]    r_s4_p [3];
    logic signed [SW-1:0]    r_s4_s;
    logic                    r_s4_le;
    logic                    r_s4_eq;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s4_p[i] <= PW'(((PRW + 1)'(r_s3_prod[i]) + RND_P) >>> FRACTION_BITS);
        end
        r_s4_v  <= r_s3_v;
        r_s4_s  <= r_s3_s;
        r_s4_le <= r_s3_le;
        r_s4_eq <= r_s3_eq;
    end

    // ---------------------------------------------------------------------
    // Stage 5: tangential part, magnitudes and the restitution products.
    // ---------------------------------------------------------------------
    logic signed [VAL_W-1:0] r_s5_v   [3];
    logic signed [EW-1:0]    r_s5_t   [3];
    logic [PW-1:0]           r_s5_mag [3];
    logic signed [RPW-1:0]   r_s5_rp  [3];
    logic signed [SW-1:0]    r_s5_s;
    logic                    r_s5_le;
    logic                    r_s5_eq;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s5_t[i]   <= EW'(r_s4_v[i]) - EW'(r_s4_p[i]);
            r_s5_mag[i] <= r_s4_p[i][PW-1] ? PW'(-r_s4_p[i]) : PW'(r_s4_p[i]);
            r_s5_rp[i]  <= RPW'($signed({1'b0, cfg_rest})) * RPW'(r_s4_p[i]);
        end
        r_s5_v  <= r_s4_v;
        r_s5_s  <= r_s4_s;
        r_s5_le <= r_s4_le;
        r_s5_eq <= r_s4_eq;
    end

    // ---------------------------------------------------------------------
    // Stage 6: per-component small test, squares, bounce term rounding.
    // ---------------------------------------------------------------------
    logic signed [VAL_W-1:0] r_s6_v  [3];
    logic signed [EW-1:0]    r_s6_t  [3];
    logic signed [BW-1:0]    r_s6_br [3];
    logic [SQW-1:0]          r_s6_sq [3];
    logic                    r_s6_comp_small;
    logic signed [SW-1:0]    r_s6_s;
    logic                    r_s6_le;
    logic                    r_s6_eq;
    logic [THR_W-1:0]        n_s6_m  [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_s6_m[i] = r_s5_mag[i][THR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s6_sq[i] <= SQW'(n_s6_m[i]) * SQW'(n_s6_m[i]);
            r_s6_br[i] <= BW'(((RPW + 1)'(r_s5_rp[i]) + RND_R) >>> RST_FRAC);
        end
        r_s6_comp_small <= (r_s5_mag[0] < PW'(THR)) && (r_s5_mag[1] < PW'(THR))
                           && (r_s5_mag[2] < PW'(THR));
        r_s6_v  <= r_s5_v;
        r_s6_t  <= r_s5_t;
        r_s6_s  <= r_s5_s;
        r_s6_le <= r_s5_le;
        r_s6_eq <= r_s5_eq;
    end

    // ---------------------------------------------------------------------
    // Stage 7: small-speed zeroing, classification and saturation.
    // ---------------------------------------------------------------------
    // A collision needs a negative speed, which the zeroing rules out, so the
    // bounce term can use the normal part as computed.
    logic                 n_small;
    logic signed [SW-1:0] n_s_eff;
    t_contact             n_state;
    logic signed [EW-1:0] n_bounce [3];
    t_out                 n_res;
    t_out                 r_res;

    always_comb begin
        n_small = r_s6_comp_small && ((r_s6_sq[0] + r_s6_sq[1] + r_s6_sq[2]) < THR_SQ);
        n_s_eff = n_small ? '0 : r_s6_s;
        if (n_s_eff[SW-1] && r_s6_le) begin
            n_state = CS_COLLISION;
        end else if (n_s_eff == '0 && r_s6_eq) begin
            n_state = CS_RESTING;
        end else begin
            n_state = CS_NONE;
        end
        for (int i = 0; i < 3; i++) begin
            n_bounce[i] = (n_state == CS_COLLISION) ? r_s6_t[i] - EW'(r_s6_br[i])
                                                    : EW'(r_s6_v[i]);
        end
        n_res.contact_state = n_state;
        n_res.new_vel_x     = $signed(sat32(n_bounce[0]));
        n_res.new_vel_y     = $signed(sat32(n_bounce[1]));
        n_res.new_vel_z     = $signed(sat32(n_bounce[2]));
        n_res.normal_speed  = $signed(sat32(EW'(n_s_eff)));
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_result = r_res;
    assign o_done   = r_vld[LAT-1];

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(in_accept, LAT))
        else $error("result strobe without a matching accepted transaction");

    a_collision_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.contact_state == CS_COLLISION) |-> o_result.normal_speed[VAL_W-1])
        else $error("collision reported with a non-negative normal speed");

    a_resting_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.contact_state == CS_RESTING) |-> (o_result.normal_speed == '0))
        else $error("resting contact reported with a nonzero normal speed");

    a_echo_vel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.contact_state != CS_COLLISION)
            |-> (o_result.new_vel_x == $past(i_item.vel_x, LAT)))
        else $error("velocity not echoed when no collision");

endmodule

`default_nettype wire

// ===== rtl/spc_cfg_regs.sv =====
// Configuration register file of the sphere-plane collision block.
`default_nettype none

module spc_cfg_regs
    import spc_pkg::*;
#(
    parameter int FRACTION_BITS = 16,
    parameter int NORMAL_W      = 18
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0]        i_cfg_data,
    output logic signed [NORMAL_W-1:0]       o_nrm [3],
    output logic signed [VAL_W-1:0]          o_pnt [3],
    output logic [RAD_W-1:0]                 o_radius,
    output logic [RST_W-1:0]                 o_rest
);

    logic signed [NORMAL_W-1:0] r_nrm [3];
    logic signed [VAL_W-1:0]    r_pnt [3];
    logic [RAD_W-1:0]           r_radius;
    logic [RST_W-1:0]           r_rest;

    // Writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nrm[0] <= '0;
            r_nrm[1] <= NORMAL_W'(1) << FRACTION_BITS;
            r_nrm[2] <= '0;
            r_pnt[0] <= '0;
            r_pnt[1] <= '0;
            r_pnt[2] <= '0;
            r_radius <= RAD_W'(1) << FRACTION_BITS;
            r_rest   <= RESET_RESTITUTION;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NORMAL_X:    r_nrm[0] <= NORMAL_W'($signed(i_cfg_data[NRM_W-1:0]));
                REG_NORMAL_Y:    r_nrm[1] <= NORMAL_W'($signed(i_cfg_data[NRM_W-1:0]));
                REG_NORMAL_Z:    r_nrm[2] <= NORMAL_W'($signed(i_cfg_data[NRM_W-1:0]));
                REG_POINT_X:     r_pnt[0] <= $signed(i_cfg_data[VAL_W-1:0]);
                REG_POINT_Y:     r_pnt[1] <= $signed(i_cfg_data[VAL_W-1:0]);
                REG_POINT_Z:     r_pnt[2] <= $signed(i_cfg_data[VAL_W-1:0]);
                REG_RADIUS:      r_radius <= i_cfg_data[RAD_W-1:0];
                REG_RESTITUTION: r_rest   <= i_cfg_data[RST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_nrm    = r_nrm;
    assign o_pnt    = r_pnt;
    assign o_radius = r_radius;
    assign o_rest   = r_rest;

endmodule

`default_nettype wire

// ===== tb/sphere_plane_collision_response_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the sphere-plane collision response block.
module sphere_plane_collision_response_test;
    import spc_pkg::*;

    // Fraction bits of the block as instantiated, and the pipeline depth that the
    // block advertises. The watchdog allows many times the longest quiet stretch of
    // a correct run: the longest sender gap plus the pipeline depth.
    localparam int     FRAC      = 16;
    localparam int     LATENCY   = 7;
    localparam int     DRAIN_PAD = 3 * LATENCY;
    localparam int     WATCHDOG  = 200;
    localparam int     PHASE_LEN = 105;
    localparam int     REG_COUNT = REG_RESTITUTION + 1;

    localparam longint Q_ONE      = 64'sd1 <<< FRAC;
    localparam longint VAL_MAX    = 64'sd2147483647;
    localparam longint VAL_MIN    = -64'sd2147483648;
    localparam longint RAD_MAX    = (64'sd1 <<< RAD_W) - 1;
    localparam longint RST_MAX    = (64'sd1 <<< RST_W) - 1;
    localparam longint RST_UNITY  = 64'sd1 <<< RST_FRAC;
    localparam longint UNIT_DIAG  = 64'sd37837;
    localparam longint SMALL_THR  = (Q_ONE + 5) / 10;

    // Plane settings that the random phases walk through.
    typedef enum int {
        SET_FLOOR,
        SET_WALL_ZERO,
        SET_CEILING_EXTREME,
        SET_TILTED_RANDOM,
        SET_ZERO_NORMAL,
        SET_DIAGONAL_HARD,
        SET_DIAGONAL_NEG,
        SET_DIAGONAL_UNIT,
        SET_LOW_RADIUS,
        SET_MIXED
    } cfg_set_e;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_start     = 1'b0;
    t_in                  i_item      = '0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;
    logic                 o_busy;
    logic                 o_done;
    t_out                 o_result;
    logic                 o_cfg_ready;

    // Register copy as the block holds it, updated when a write transaction is seen.
    longint nrm_q[3] = '{0, Q_ONE, 0};
    longint pnt_q[3] = '{0, 0, 0};
    longint radius_q = Q_ONE;
    longint restit_q = RESET_RESTITUTION;

    // Register values that the stimulus aims its spheres at.
    longint plan_nrm[3] = '{0, Q_ONE, 0};
    longint plan_pnt[3] = '{0, 0, 0};
    longint plan_rad    = Q_ONE;

    t_in  sphere_q[$];
    t_out predicted_bounce_q[$];
    int   n_queued     = 0;
    int   n_responses  = 0;
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    int   gap_left     = 0;
    logic idle_on      = 1'b1;
    logic item_taken   = 1'b0;

    sphere_plane_collision_response dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Round half up, dropping the given number of fraction bits. The arithmetic
    // shift of a signed value floors, which is what rounding half up needs.
    function automatic longint round_up_shift(input longint x, input int sh);
        return (x + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > VAL_MAX) return VAL_MAX[31:0];
        if (x < VAL_MIN) return VAL_MIN[31:0];
        return x[31:0];
    endfunction

    function automatic longint abs64(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Expected response for one sphere under the current register copy.
    function automatic t_out bounce_predict(input t_in it);
        longint v[3], c[3], p[3], tg[3];
        longint dot, pdist, s, sq, ad, rs;
        logic signed [31:0] nv[3];
        logic tiny;
        t_contact cs;
        t_out r;
        int i;
        v[0] = $signed(it.vel_x);
        v[1] = $signed(it.vel_y);
        v[2] = $signed(it.vel_z);
        c[0] = $signed(it.pos_x);
        c[1] = $signed(it.pos_y);
        c[2] = $signed(it.pos_z);
        dot   = 0;
        pdist = 0;
        for (i = 0; i < 3; i++) begin
            dot   += v[i] * nrm_q[i];
            pdist += (c[i] - pnt_q[i]) * nrm_q[i];
        end
        s    = round_up_shift(dot, FRAC);
        tiny = 1'b1;
        for (i = 0; i < 3; i++) begin
            p[i]  = round_up_shift(s * nrm_q[i], FRAC);
            tg[i] = v[i] - p[i];
            if (abs64(p[i]) >= SMALL_THR) tiny = 1'b0;
        end
        // The squared magnitude is only formed once every component is below the
        // threshold, so it cannot overflow.
        if (tiny) begin
            sq = 0;
            for (i = 0; i < 3; i++) sq += p[i] * p[i];
            tiny = (sq < SMALL_THR * SMALL_THR);
        end
        // The tangential part keeps the unzeroed normal part taken out of it.
        if (tiny) begin
            for (i = 0; i < 3; i++) p[i] = 0;
            s = 0;
        end
        ad = abs64(pdist);
        rs = radius_q <<< FRAC;
        if (s < 0 && ad <= rs) cs = CS_COLLISION;
        else if (s == 0 && ad == rs) cs = CS_RESTING;
        else cs = CS_NONE;
        for (i = 0; i < 3; i++) begin
            if (cs == CS_COLLISION) nv[i] = clamp32(tg[i] - round_up_shift(restit_q * p[i], RST_FRAC));
            else nv[i] = clamp32(v[i]);
        end
        r.contact_state = cs;
        r.new_vel_x     = nv[0];
        r.new_vel_y     = nv[1];
        r.new_vel_z     = nv[2];
        r.normal_speed  = clamp32(s);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    function automatic longint full32();
        return longint'(int'($urandom));
    endfunction

    // Uniform over [-span, span]; span stays below 2^31.
    function automatic longint srand(input longint span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Most spheres are placed along the normal at a chosen signed distance from
    // the plane, often exactly at the radius, with a chosen normal speed around
    // the zeroing threshold or well beyond it. The rest are unshaped noise.
    function automatic t_in gen_sphere();
        longint u, w;
        longint vv[3], cc[3];
        logic tang_all;
        int pick, i;
        t_in it;
        if ($urandom_range(0, 99) < 12) begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            return it;
        end
        pick = $urandom_range(0, 9);
        if (pick < 3) u = $urandom_range(0, 1) ? plan_rad : -plan_rad;
        else if (pick < 7) u = srand(plan_rad);
        else if (pick < 9) u = ($urandom_range(0, 1) ? 1 : -1) * (plan_rad + $urandom_range(1, 4));
        else u = full32();
        pick = $urandom_range(0, 9);
        if (pick < 4) w = -longint'($urandom_range(6000, 1 << 22));
        else if (pick < 7) w = srand(8000);
        else if (pick < 9) w = longint'($urandom_range(1, 1 << 22));
        else w = full32();
        tang_all = ($urandom_range(0, 3) == 0);
        for (i = 0; i < 3; i++) begin
            cc[i] = plan_pnt[i] + ((plan_nrm[i] * u) >>> FRAC);
            vv[i] = (plan_nrm[i] * w) >>> FRAC;
            // Components off the normal carry a tangential part that leaves the normal
            // speed untouched; sometimes all components get one, which alters the speed.
            if (tang_all || plan_nrm[i] == 0)
                vv[i] += ($urandom_range(0, 3) == 0) ? full32() : srand(1 << 20);
        end
        it.vel_x = vv[0][31:0];
        it.vel_y = vv[1][31:0];
        it.vel_z = vv[2][31:0];
        it.pos_x = cc[0][31:0];
        it.pos_y = cc[1][31:0];
        it.pos_z = cc[2][31:0];
        return it;
    endfunction

    task automatic queue_sphere(input t_in it);
        sphere_q.push_back(it);
        n_queued++;
    endtask

    // Waits at falling edges, where the response count is stable, until every
    // queued sphere has come back.
    task automatic wait_drained();
        while (n_responses < n_queued) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // One phase: set up the plane, write every register while the block is empty,
    // then send a batch of spheres and let them all come back.
    task automatic run_phase(input cfg_set_e kind, input int count);
        longint rest;
        logic [CFG_DAT_W-1:0] word;
        int i, ax;
        for (i = 0; i < 3; i++) begin
            plan_nrm[i] = 0;
            plan_pnt[i] = full32();
        end
        plan_rad = $urandom_range(0, 64 * Q_ONE);
        rest     = $urandom_range(0, RST_UNITY);
        case (kind)
            SET_FLOOR: begin
                plan_nrm[1] = Q_ONE;
            end
            SET_WALL_ZERO: begin
                plan_nrm[0] = Q_ONE;
                for (i = 0; i < 3; i++) plan_pnt[i] = 0;
                plan_rad = 0;
                rest     = 0;
            end
            SET_CEILING_EXTREME: begin
                plan_nrm[2] = -Q_ONE;
                plan_pnt[0] = VAL_MAX;
                plan_pnt[1] = VAL_MIN;
                plan_pnt[2] = VAL_MAX;
                plan_rad    = RAD_MAX;
                rest        = RST_UNITY;
            end
            SET_TILTED_RANDOM: begin
                for (i = 0; i < 3; i++) plan_nrm[i] = srand(Q_ONE);
            end
            SET_ZERO_NORMAL: begin
                // With no normal every sphere sits at distance zero, so a zero
                // radius makes each one a resting contact.
                plan_rad = 0;
                rest     = RST_MAX;
            end
            SET_DIAGONAL_HARD: begin
                for (i = 0; i < 3; i++) plan_nrm[i] = Q_ONE;
                rest = RST_MAX;
            end
            SET_DIAGONAL_NEG: begin
                for (i = 0; i < 3; i++) begin
                    plan_nrm[i] = -Q_ONE;
                    plan_pnt[i] = VAL_MIN;
                end
                rest = RST_UNITY + RST_UNITY / 2;
            end
            SET_DIAGONAL_UNIT: begin
                plan_nrm[0] = UNIT_DIAG;
                plan_nrm[1] = -UNIT_DIAG;
                plan_nrm[2] = UNIT_DIAG;
            end
            SET_LOW_RADIUS: begin
                plan_nrm[1] = -Q_ONE;
                for (i = 0; i < 3; i++) plan_pnt[i] = srand(1 << 20);
                plan_rad = $urandom_range(0, Q_ONE / 4);
                rest     = $urandom_range(0, RST_MAX);
            end
            default: begin
                ax = $urandom_range(0, 2);
                if ($urandom_range(0, 1)) plan_nrm[ax] = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
                else for (i = 0; i < 3; i++) plan_nrm[i] = srand(Q_ONE);
                rest = $urandom_range(0, RST_MAX);
            end
        endcase

        // Bits above a narrow register's width carry noise; the block must drop them.
        for (i = 0; i < 3; i++) begin
            word = $urandom;
            word[NRM_W-1:0] = plan_nrm[i][NRM_W-1:0];
            cfg_write(REG_NORMAL_X + i, word);
        end
        for (i = 0; i < 3; i++) cfg_write(REG_POINT_X + i, plan_pnt[i][31:0]);
        word = $urandom;
        word[RAD_W-1:0] = plan_rad[RAD_W-1:0];
        cfg_write(REG_RADIUS, word);
        word = $urandom;
        word[RST_W-1:0] = rest[RST_W-1:0];
        cfg_write(REG_RESTITUTION, word);
        // A write to an index past the last register must change nothing.
        cfg_write($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1), $urandom);

        // The last phase, and one in the middle, run with no sender gaps at all.
        idle_on = (kind != SET_MIXED) && (kind != SET_TILTED_RANDOM);
        for (i = 0; i < count; i++) queue_sphere(gen_sphere());
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        wait_drained();
    endtask

    // Driver: moves to the next sphere at the falling edge after a transaction is
    // taken, inserting idle bursts while idling is enabled.
    // During an idle burst, the item bus carries noise that the block must ignore.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || item_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_start  <= 1'b0;
                i_item   <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end else if (sphere_q.size() != 0 && idle_on && $urandom_range(0, 5) == 0) begin
                gap_left <= $urandom_range(0, 13);
                i_start  <= 1'b0;
                i_item   <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            end else if (sphere_q.size() != 0) begin
                i_start <= 1'b1;
                i_item  <= sphere_q.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: checks each response against the oldest prediction, predicts every
    // accepted transaction, tracks register writes, and runs the watchdog.
    // Responses are checked before a new prediction is queued; with a pipeline
    // depth of seven the two never refer to the same transaction.
    always @(posedge i_clk) begin
        t_out want;
        item_taken <= i_start && !o_busy;
        if (i_rst_n) begin
            if (o_done) begin
                n_responses++;
                if (predicted_bounce_q.size() == 0) begin
                    $error("response with no transaction outstanding");
                    mismatches++;
                end else begin
                    want = predicted_bounce_q.pop_front();
                    check_field("contact_state", 32'(want.contact_state),
                                32'(o_result.contact_state));
                    check_field("new_vel_x", want.new_vel_x, o_result.new_vel_x);
                    check_field("new_vel_y", want.new_vel_y, o_result.new_vel_y);
                    check_field("new_vel_z", want.new_vel_z, o_result.new_vel_z);
                    check_field("normal_speed", want.normal_speed, o_result.normal_speed);
                end
            end
            if (i_start && !o_busy) predicted_bounce_q.push_back(bounce_predict(i_item));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z:
                        nrm_q[i_cfg_index - REG_NORMAL_X] = $signed(i_cfg_data[NRM_W-1:0]);
                    REG_POINT_X, REG_POINT_Y, REG_POINT_Z:
                        pnt_q[i_cfg_index - REG_POINT_X] = $signed(i_cfg_data);
                    REG_RADIUS:
                        radius_q = i_cfg_data[RAD_W-1:0];
                    REG_RESTITUTION:
                        restit_q = i_cfg_data[RST_W-1:0];
                    default: ;
                endcase
            end
            if (o_done || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG) begin
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int k;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed spheres against the reset plane: floor normal, plane through the
        // origin, radius 1.0, restitution 0.8.
        queue_sphere('{0, 0, 0, 0, 0, 0});
        queue_sphere('{VAL_MAX[31:0], VAL_MAX[31:0], VAL_MAX[31:0],
                       VAL_MAX[31:0], VAL_MAX[31:0], VAL_MAX[31:0]});
        queue_sphere('{VAL_MIN[31:0], VAL_MIN[31:0], VAL_MIN[31:0],
                       VAL_MIN[31:0], VAL_MIN[31:0], VAL_MIN[31:0]});
        // Plain collision, then collisions exactly at the radius on both sides.
        queue_sphere('{0, -2 * Q_ONE, 0, 0, Q_ONE / 2, 0});
        queue_sphere('{Q_ONE, -Q_ONE, 3, 0, Q_ONE, 0});
        queue_sphere('{0, -Q_ONE, -Q_ONE, 0, -Q_ONE, 0});
        // Just beyond the radius: approaching but no contact.
        queue_sphere('{0, -Q_ONE, 0, 0, Q_ONE + 1, 0});
        // Resting contact, with zero normal speed and with a speed just under 0.1.
        queue_sphere('{5, 0, -7, 0, Q_ONE, 0});
        queue_sphere('{0, -(SMALL_THR - 1), 0, 0, -Q_ONE, 0});
        // Exactly 0.1 is no longer small, so it collides; moving away it does not.
        queue_sphere('{0, -SMALL_THR, 0, 0, Q_ONE, 0});
        queue_sphere('{0, SMALL_THR, 0, 0, Q_ONE, 0});
        // Tangential extremes carried through a collision.
        queue_sphere('{VAL_MAX[31:0], VAL_MIN[31:0], VAL_MIN[31:0],
                       VAL_MIN[31:0], 0, VAL_MAX[31:0]});
        // A tiny normal speed is zeroed, and away from the radius that is no contact.
        queue_sphere('{0, -1, 0, 0, 0, 0});
        wait_drained();

        for (k = 0; k <= SET_MIXED; k++) run_phase(cfg_set_e'(k), PHASE_LEN);

        repeat (DRAIN_PAD) @(posedge i_clk);
        if (predicted_bounce_q.size() != 0) begin
            $error("%0d predicted responses never arrived", predicted_bounce_q.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
